// ===== src/mtns_pkg.sv =====
package mtns_pkg;

   localparam int MAX_MARKERS = 32;
   localparam int SLOT_W      = 5;
   localparam int CNT_W       = 6;
   localparam int POS_W       = 64;
   localparam int MODE_W      = 3;
   localparam int ENTRY_W     = POS_W + 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE     = 3'd0,
      MODE_READ      = 3'd1,
      MODE_EXACT     = 3'd2,
      MODE_FIRST_OFF = 3'd3,
      MODE_CLOSEST   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [SLOT_W-1:0]       marker_slot;
      logic                    new_enabled;
      logic signed [POS_W-1:0] new_position;
      logic signed [POS_W-1:0] query_time;
   } req_item_type;

endpackage

// ===== src/mtns_req_if.sv =====
interface mtns_req_if import mtns_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [SLOT_W-1:0]       marker_slot;
   logic                    new_enabled;
   logic signed [POS_W-1:0] new_position;
   logic signed [POS_W-1:0] query_time;

   modport source (output valid, mode, marker_slot, new_enabled, new_position, query_time,
                   input ready);
   modport sink   (input valid, mode, marker_slot, new_enabled, new_position, query_time,
                   output ready);
endinterface

// ===== src/mtns_rsp_if.sv =====
interface mtns_rsp_if import mtns_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [SLOT_W-1:0]       slot_found;
   logic                    slot_enabled;
   logic signed [POS_W-1:0] slot_position;
   logic signed [POS_W-1:0] query_offset;

   modport source (output valid, found, slot_found, slot_enabled, slot_position,
                   query_offset, input ready);
   modport sink   (input valid, found, slot_found, slot_enabled, slot_position,
                   query_offset, output ready);
endinterface

// ===== src/mtns_ram.sv =====
module mtns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/marker_table_nearest_search.sv =====
// A write, an out-of-range read or a spare mode goes from the start state straight to the
// done state and the response register; a read scans its one slot and the three search modes
// scan N slots, N = marker count in use (min(csr, 32)), one slot per cycle through the RAM.
// One request word is worked at a time: a new word is taken only once the last response is loaded.
// Reset (synchronous, active high) clears all slot valid bits (table reads as all zero),
// sets the marker count to 32 and empties the response register.
module marker_table_nearest_search import mtns_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mtns_req_if.sink           req_chan,
   mtns_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data
);

   // ---------------------------------------------------------------- control state
   state_type          state_ff, state_in;
   req_item_type       item_ff;
   logic [CNT_W-1:0]   marker_count_ff;
   logic [CNT_W-1:0]   slots_used;

   // One valid bit per slot; a slot never written reads as disabled, position zero.
   logic [MAX_MARKERS-1:0] valid_ff;

   // Scan address generator: reads slots issue_idx .. issue_end-1.
   logic [CNT_W-1:0]   issue_idx_ff, issue_end_ff;

   // Stage 1: RAM read in flight.
   logic               p1_vld_ff;
   logic [SLOT_W-1:0]  p1_idx_ff;

   // Stage 2: entry with its distance and equality flag.
   logic               s2_vld_ff;
   logic [SLOT_W-1:0]  s2_idx_ff;
   logic               s2_en_ff;
   logic [POS_W-1:0]   s2_pos_ff;
   logic [POS_W-1:0]   s2_dist_ff;
   logic               s2_eq_ff;

   // Running best match.
   logic               have_ff;
   logic [SLOT_W-1:0]  best_idx_ff;
   logic               best_en_ff;
   logic [POS_W-1:0]   best_pos_ff;
   logic [POS_W-1:0]   best_dist_ff;

   // Response register, parts the two sides.
   logic               rsp_vld_ff;
   logic               rsp_found_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_en_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [POS_W-1:0]   rsp_delta_ff;

   // ---------------------------------------------------------------- comb control
   logic               accept;
   logic               slot_in_range;
   logic               scan_go;
   logic               start_write;
   logic               issue_rd;
   logic               pipe_busy;
   logic               load_out;
   logic               take;

   logic [ENTRY_W-1:0] ram_rd_data;
   logic               entry_en;
   logic [POS_W-1:0]   entry_pos;
   logic [POS_W-1:0]   q_bias, p_bias;
   logic [POS_W:0]     diff_qp;
   logic [POS_W-1:0]   diff_pq;
   logic [POS_W-1:0]   entry_dist;

   // count in use saturates at the table depth
   assign slots_used = (marker_count_ff > CNT_W'(MAX_MARKERS)) ? CNT_W'(MAX_MARKERS)
                                                                : marker_count_ff;
   assign slot_in_range = ({1'b0, item_ff.marker_slot} < slots_used);

   assign accept   = req_chan.valid && req_chan.ready;
   assign issue_rd = (state_ff == ST_SCAN) && (issue_idx_ff < issue_end_ff);
   assign pipe_busy = issue_rd || p1_vld_ff || s2_vld_ff;

   always_comb begin
      case (item_ff.mode)
         MODE_READ:      scan_go = slot_in_range;
         MODE_EXACT:     scan_go = 1'b1;
         MODE_FIRST_OFF: scan_go = 1'b1;
         MODE_CLOSEST:   scan_go = 1'b1;
         default:        scan_go = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_START;
         end
         ST_START: begin
            state_in = scan_go ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (!pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      start_write    = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_START: start_write = (item_ff.mode == MODE_WRITE) && slot_in_range;
         ST_SCAN:  ;
         ST_DONE:  load_out = !rsp_vld_ff || rsp_chan.ready;
         default:  ;
      endcase
   end

   // ---------------------------------------------------------------- table memory
   mtns_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_MARKERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (start_write),
      .wr_addr (item_ff.marker_slot),
      .wr_data ({item_ff.new_enabled, item_ff.new_position}),
      .rd_en   (issue_rd),
      .rd_addr (issue_idx_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // mask entries never written since reset
   assign entry_en  = ram_rd_data[POS_W] && valid_ff[p1_idx_ff];
   assign entry_pos = valid_ff[p1_idx_ff] ? ram_rd_data[POS_W-1:0] : '0;

   // |query - pos| on offset-binary values, both differences in parallel
   assign q_bias     = item_ff.query_time ^ {1'b1, {(POS_W-1){1'b0}}};
   assign p_bias     = entry_pos ^ {1'b1, {(POS_W-1){1'b0}}};
   assign diff_qp    = {1'b0, q_bias} - {1'b0, p_bias};
   assign diff_pq    = p_bias - q_bias;
   assign entry_dist = diff_qp[POS_W] ? diff_pq : diff_qp[POS_W-1:0];

   // does the stage 2 entry replace the best so far
   always_comb begin
      case (item_ff.mode)
         MODE_READ:      take = !have_ff;
         MODE_EXACT:     take = !have_ff && s2_en_ff && s2_eq_ff;
         MODE_FIRST_OFF: take = !have_ff && !s2_en_ff;
         MODE_CLOSEST:   take = s2_en_ff && (!have_ff || (s2_dist_ff < best_dist_ff));
         default:        take = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         marker_count_ff <= CNT_W'(MAX_MARKERS);
         valid_ff        <= '0;
         p1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) marker_count_ff <= csr_wr_data;
         if (start_write) valid_ff[item_ff.marker_slot] <= 1'b1;
         p1_vld_ff <= issue_rd;
         s2_vld_ff <= p1_vld_ff;
         if (load_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (accept) item_ff <= {req_chan.mode, req_chan.marker_slot, req_chan.new_enabled,
                              req_chan.new_position, req_chan.query_time};

      if (state_ff == ST_START) begin
         if (item_ff.mode == MODE_READ) begin
            issue_idx_ff <= {1'b0, item_ff.marker_slot};
            issue_end_ff <= {1'b0, item_ff.marker_slot} + CNT_W'(1);
         end else begin
            issue_idx_ff <= '0;
            issue_end_ff <= slots_used;
         end
         // a write echoes the slot as it now stands
         have_ff      <= start_write;
         best_idx_ff  <= start_write ? item_ff.marker_slot : '0;
         best_en_ff   <= start_write && item_ff.new_enabled;
         best_pos_ff  <= start_write ? item_ff.new_position : '0;
         best_dist_ff <= '0;
      end else begin
         if (issue_rd) issue_idx_ff <= issue_idx_ff + CNT_W'(1);
         if (s2_vld_ff && take) begin
            have_ff      <= 1'b1;
            best_idx_ff  <= s2_idx_ff;
            best_en_ff   <= s2_en_ff;
            best_pos_ff  <= s2_pos_ff;
            best_dist_ff <= s2_dist_ff;
         end
      end

      p1_idx_ff  <= issue_idx_ff[SLOT_W-1:0];
      s2_idx_ff  <= p1_idx_ff;
      s2_en_ff   <= entry_en;
      s2_pos_ff  <= entry_pos;
      s2_dist_ff <= entry_dist;
      s2_eq_ff   <= (entry_pos == item_ff.query_time);

      if (load_out) begin
         rsp_found_ff <= have_ff;
         rsp_slot_ff  <= best_idx_ff;
         rsp_en_ff    <= best_en_ff;
         rsp_pos_ff   <= best_pos_ff;
         rsp_delta_ff <= (have_ff && (item_ff.mode == MODE_CLOSEST))
                         ? (item_ff.query_time - best_pos_ff) : '0;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.slot_found    = rsp_slot_ff;
   assign rsp_chan.slot_enabled  = rsp_en_ff;
   assign rsp_chan.slot_position = rsp_pos_ff;
   assign rsp_chan.query_offset  = rsp_delta_ff;

`ifndef SYNTHESIS
   // a taken request word always starts work on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_START))
      else $error("request taken without starting work");

   // scan never reads past the slots in use
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_rd |-> (issue_idx_ff < slots_used))
      else $error("scan read beyond count in use");

   // result is only formed once the scan pipeline has drained
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!p1_vld_ff && !s2_vld_ff))
      else $error("result formed with scan data in flight");

   // a reported slot is always inside the count in use
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_found_ff) |-> ({1'b0, rsp_slot_ff} < slots_used))
      else $error("found slot outside count in use");
`endif

endmodule
